// ----- design/mmp_pkg.sv -----
// mmp_pkg: shared constants and controller/datapath handshake types for the
// MD5 message padder. No dependencies.
package mmp_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned WIDX_W      = POS_W - 2;

  localparam logic [7:0]        PAD_BYTE    = 8'h80;
  localparam logic [POS_W-1:0]  LEN_POS     = POS_W'(BLOCK_BYTES - 8);
  localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(BLOCK_BYTES - 1);
  localparam logic [WIDX_W-1:0] LEN_LO_WIDX = WIDX_W'((BLOCK_BYTES - 8) / 4);
  localparam logic [WIDX_W-1:0] LAST_WIDX   = WIDX_W'(BLOCK_BYTES / 4 - 1);

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic data_load;
    logic pad_first;
    logic pad_next;
  } mmp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pad_final;
  } mmp_stat_t;

endpackage

// ----- design/mmp_in_if.sv -----
// mmp_in_if: input channel of the MD5 padder (command and data byte).
// No dependencies.
interface mmp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// ----- design/mmp_out_if.sv -----
// mmp_out_if: output channel of the MD5 padder (block words and markers).
// No dependencies.
interface mmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_of_block;
  logic        last_of_message;

  modport source (output valid, output word, output last_of_block,
                  output last_of_message, input ready);
  modport sink   (input valid, input word, input last_of_block,
                  input last_of_message, output ready);
endinterface

// ----- design/mmp_datapath.sv -----
// mmp_datapath: byte counter, word packer, padding word generator and output
// register of the MD5 padder. Depends on mmp_pkg.
module mmp_datapath
  import mmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mmp_cmd_t    cmd_i,
  output mmp_stat_t   stat_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_o,
  output logic        last_of_block_o,
  output logic        last_of_message_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [23:0]        partial_q, partial_d;
  logic [WIDX_W-1:0]  widx_q, widx_d;
  logic               extra_q, extra_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        word_q, word_d;
  logic               lob_q, lob_d, lom_q, lom_d;

  logic [POS_W-1:0]   pos;
  logic [1:0]         lane;
  logic [4:0]         shamt;
  logic [63:0]        bit_len;
  logic               slot_free;
  logic               first_extra;
  logic               pad_final;
  logic               load;

  assign pos         = count_q[POS_W-1:0];
  assign lane        = pos[1:0];
  assign shamt       = {lane, 3'b000};
  assign bit_len     = {count_q, 3'b000};
  assign slot_free   = !out_valid_q || out_ready_i;
  assign first_extra = (pos >= LEN_POS);
  assign pad_final   = !extra_q && (widx_q == LAST_WIDX);
  assign load        = (cmd_i.data_load && (lane == 2'd3)) || cmd_i.pad_first
                       || cmd_i.pad_next;

  assign stat_o.slot_free = slot_free;
  assign stat_o.pad_final = pad_final;

  always_comb begin
    count_d     = count_q;
    partial_d   = partial_q;
    widx_d      = widx_q;
    extra_d     = extra_q;
    word_d      = word_q;
    lob_d       = lob_q;
    lom_d       = lom_q;
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    if (cmd_i.data_load) begin
      count_d = count_q + COUNT_W'(1);
      if (lane == 2'd3) begin
        partial_d = '0;
        word_d    = {data_byte_i, partial_q};
        lob_d     = (pos == LAST_POS);
        lom_d     = 1'b0;
      end else begin
        partial_d = partial_q | 24'({24'(data_byte_i)} << shamt);
      end
    end else if (cmd_i.pad_first) begin
      word_d  = {8'h00, partial_q} | (32'(PAD_BYTE) << shamt);
      lob_d   = (pos[POS_W-1:2] == LAST_WIDX);
      lom_d   = 1'b0;
      widx_d  = pos[POS_W-1:2] + WIDX_W'(1);
      extra_d = first_extra && (pos[POS_W-1:2] != LAST_WIDX);
    end else if (cmd_i.pad_next) begin
      if (!extra_q && widx_q == LEN_LO_WIDX) begin
        word_d = bit_len[31:0];
      end else if (pad_final) begin
        word_d = bit_len[63:32];
      end else begin
        word_d = '0;
      end
      lob_d   = (widx_q == LAST_WIDX);
      lom_d   = pad_final;
      widx_d  = widx_q + WIDX_W'(1);
      extra_d = extra_q && (widx_q != LAST_WIDX);
      if (pad_final) begin
        count_d   = '0;
        partial_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      partial_q   <= '0;
      widx_q      <= '0;
      extra_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      partial_q   <= partial_d;
      widx_q      <= widx_d;
      extra_q     <= extra_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    lob_q  <= lob_d;
    lom_q  <= lom_d;
  end

  assign out_valid_o       = out_valid_q;
  assign word_o            = word_q;
  assign last_of_block_o   = lob_q;
  assign last_of_message_o = lom_q;

  // padding words only go out when the output register can take them
  a_pad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pad_first || cmd_i.pad_next) |-> slot_free)
    else $error("padding word loaded into busy output register");

  // the final word of a message always closes a block
  a_lom_lob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && lom_q) |-> lob_q)
    else $error("message end not on block boundary");

  // message state is cleared after the length word goes out
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pad_next && pad_final) |=> (count_q == '0 && partial_q == '0))
    else $error("byte count not cleared after message");

endmodule

// ----- design/mmp_ctrl.sv -----
// mmp_ctrl: controller of the MD5 padder; accepts transactions and steps
// through the padding words. Depends on mmp_pkg.
module mmp_ctrl
  import mmp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_ready_o,
  output mmp_cmd_t  cmd_o,
  input  mmp_stat_t stat_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PAD  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_END) begin
            cmd_o.pad_first = 1'b1;
            state_d         = ST_PAD;
          end else begin
            cmd_o.data_load = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (stat_i.slot_free) begin
          cmd_o.pad_next = 1'b1;
          if (stat_i.pad_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/md5_message_padder.sv -----
// md5_message_padder: MD5 padding of a byte stream into 32-bit block words.
// A word shows in the cycle after its last byte. Throughput: one data
// byte per cycle while out_o is free; an end command yields 3 to 18 words,
// one per cycle while the sink takes them, and input stalls until the last.
// Reset (async, active low) clears the byte count, partial word and output.
// Depends on mmp_pkg, mmp_in_if, mmp_out_if, mmp_ctrl, mmp_datapath.
module md5_message_padder
  import mmp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  mmp_in_if.sink   in_i,
  mmp_out_if.source out_o
);

  mmp_cmd_t  cmd;
  mmp_stat_t stat;

  mmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mmp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .data_byte_i       (in_i.data_byte),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .word_o            (out_o.word),
    .last_of_block_o   (out_o.last_of_block),
    .last_of_message_o (out_o.last_of_message)
  );

endmodule
